@@ rtl/lbs_pkg.sv @@
// Shared types, codes and the brightness table for the LED breathing sequencer.
// No dependencies.
`default_nettype none

package lbs_pkg;

    localparam int unsigned CntW   = 8;
    localparam int unsigned DutyW  = 5;
    localparam int unsigned ColW   = 2;
    localparam int unsigned IdxW   = 6;
    localparam logic [CntW-1:0]  StepTop  = 8'd63;
    localparam logic [DutyW-1:0] LevelDark = 5'd1;

    // configuration register indexes
    localparam logic [1:0] RegTickGap    = 2'd0;
    localparam logic [1:0] RegHoldBright = 2'd1;
    localparam logic [1:0] RegHoldDark   = 2'd2;

    // phase codes as they appear on the result
    localparam logic [1:0] PhRise   = 2'd0;
    localparam logic [1:0] PhBright = 2'd1;
    localparam logic [1:0] PhFall   = 2'd2;
    localparam logic [1:0] PhDark   = 2'd3;

    typedef enum logic [3:0] {
        S_RISE   = 4'b0001,
        S_BRIGHT = 4'b0010,
        S_FALL   = 4'b0100,
        S_DARK   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [CntW-1:0] tick_gap;
        logic [CntW-1:0] hold_bright;
        logic [CntW-1:0] hold_dark;
    } t_cfg;

    typedef struct packed {
        logic [DutyW-1:0] blue_duty;
        logic [DutyW-1:0] orange_duty;
        logic [1:0]       phase;
    } t_res;

    function automatic logic [DutyW-1:0] level_lookup(input logic [IdxW-1:0] idx);
        logic [DutyW-1:0] lv;
        begin
            case (idx)
                6'd0, 6'd1, 6'd2, 6'd3:             lv = 5'd1;
                6'd4, 6'd5, 6'd6, 6'd7:             lv = 5'd2;
                6'd8, 6'd9, 6'd10, 6'd11:           lv = 5'd3;
                6'd12, 6'd13, 6'd14:                lv = 5'd4;
                6'd15, 6'd16, 6'd17:                lv = 5'd5;
                6'd18, 6'd19, 6'd20:                lv = 5'd6;
                6'd21, 6'd22, 6'd23:                lv = 5'd7;
                6'd24, 6'd25, 6'd26:                lv = 5'd8;
                6'd27, 6'd28:                       lv = 5'd9;
                6'd29, 6'd30:                       lv = 5'd10;
                6'd31, 6'd32:                       lv = 5'd11;
                6'd33, 6'd34:                       lv = 5'd12;
                6'd35, 6'd36:                       lv = 5'd13;
                6'd37, 6'd38:                       lv = 5'd14;
                6'd39, 6'd40:                       lv = 5'd15;
                6'd41, 6'd42:                       lv = 5'd16;
                6'd43, 6'd44:                       lv = 5'd17;
                6'd45, 6'd46:                       lv = 5'd18;
                6'd47, 6'd48:                       lv = 5'd19;
                6'd49, 6'd50:                       lv = 5'd20;
                6'd51, 6'd52:                       lv = 5'd21;
                6'd53, 6'd54:                       lv = 5'd22;
                6'd55, 6'd56:                       lv = 5'd23;
                6'd57:                              lv = 5'd24;
                6'd58:                              lv = 5'd25;
                6'd59:                              lv = 5'd26;
                6'd60:                              lv = 5'd27;
                6'd61:                              lv = 5'd28;
                6'd62:                              lv = 5'd29;
                default:                            lv = 5'd31;
            endcase
            return lv;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/led_breathe_sequencer_unit.sv @@
// LED breathing fade sequencer, top level.
// Instantiates lbs_prescale, lbs_seq and lbs_outbuf; depends on lbs_pkg.
//
// Usage:
//  - Input channel: one word per tick (i_in_valid, o_in_stall, i_colour_code).
//    A word is taken at a clock edge with i_in_valid high and o_in_stall low.
//  - The prescaler fires once every tick_gap words (0 or 1: every word).
//    Each firing word yields one result word; other words yield nothing.
//  - Output channel: o_out_valid, i_out_stall, o_blue_duty, o_orange_duty,
//    o_phase. A result is taken when o_out_valid is high and i_out_stall low.
//  - The result of a firing word is registered in the output buffer.
//  - Throughput: one word per cycle unless stalled; state update and table lookup
//    finish in the cycle a word is taken; the result register decouples outputs.
//  - Stall: a skid entry behind the result register absorbs one word while
//    the receiver stalls; o_in_stall rises only when that entry is occupied.
//  - Config: i_cfg_we writes register i_cfg_index (0 tick_gap, 1 hold_bright,
//    2 hold_dark); index 3 is ignored. Write only while idle.
//  - Reset (synchronous, active low): tick_gap 1, holds 0, sequencer in the
//    rise phase at table index 0, output buffer empty.
`default_nettype none

module led_breathe_sequencer_unit
    import lbs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [CntW-1:0]  i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic [ColW-1:0]  i_colour_code,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [DutyW-1:0]      o_blue_duty,
    output logic [DutyW-1:0]      o_orange_duty,
    output logic [1:0]            o_phase
);

    t_cfg r_cfg;
    logic in_take;
    logic fire;
    t_res seq_res;
    t_res out_res;
    logic buf_full;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_gap    <= 8'd1;
            r_cfg.hold_bright <= '0;
            r_cfg.hold_dark   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegTickGap:    r_cfg.tick_gap    <= i_cfg_data;
                RegHoldBright: r_cfg.hold_bright <= i_cfg_data;
                RegHoldDark:   r_cfg.hold_dark   <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    assign o_in_stall = buf_full;
    assign in_take    = i_in_valid && !buf_full;

    lbs_prescale u_prescale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (in_take),
        .i_tick_gap (r_cfg.tick_gap),
        .o_fire     (fire)
    );

    // step the sequencer only on firing words
    lbs_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (in_take && fire),
        .i_cfg         (r_cfg),
        .i_colour_code (i_colour_code),
        .o_res         (seq_res)
    );

    lbs_outbuf u_outbuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (in_take && fire),
        .i_res       (seq_res),
        .i_out_stall (i_out_stall),
        .o_full      (buf_full),
        .o_valid     (o_out_valid),
        .o_res       (out_res)
    );

    assign o_blue_duty   = out_res.blue_duty;
    assign o_orange_duty = out_res.orange_duty;
    assign o_phase       = out_res.phase;

endmodule

`default_nettype wire

@@ rtl/lbs_prescale.sv @@
// Tick prescaler: counts accepted words and flags the ones that fire a step.
// Depends on lbs_pkg.
`default_nettype none

module lbs_prescale
    import lbs_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [CntW-1:0] i_tick_gap,
    output logic                 o_fire
);

    logic [CntW-1:0] r_count;
    logic [CntW-1:0] n_count;
    logic [CntW-1:0] cnt_inc;

    always_comb begin
        cnt_inc = r_count + 8'd1;
        o_fire  = (cnt_inc >= i_tick_gap);
        n_count = o_fire ? '0 : cnt_inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_take) begin
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lbs_seq.sv @@
// Four-phase breathing sequencer: phase and step registers plus level lookup.
// Depends on lbs_pkg.
`default_nettype none

module lbs_seq
    import lbs_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire t_cfg            i_cfg,
    input  wire logic [ColW-1:0] i_colour_code,
    output t_res                 o_res
);

    t_phase          r_phase, n_phase;
    logic [CntW-1:0] r_step, n_step;
    logic [CntW-1:0] step_inc;
    logic [DutyW-1:0] level;

    always_comb begin
        step_inc = r_step + 8'd1;
        n_phase  = r_phase;
        n_step   = r_step;
        level    = LevelDark;
        o_res.phase = PhRise;
        case (r_phase)
            S_RISE: begin
                o_res.phase = PhRise;
                level  = level_lookup(r_step[IdxW-1:0]);
                n_step = step_inc;
                if (step_inc > StepTop) begin
                    if (i_cfg.hold_bright != '0) begin
                        n_phase = S_BRIGHT;
                        n_step  = '0;
                    end else begin
                        n_phase = S_FALL;
                        n_step  = StepTop;
                    end
                end
            end
            S_BRIGHT: begin
                o_res.phase = PhBright;
                level  = level_lookup(StepTop[IdxW-1:0]);
                n_step = step_inc;
                if (step_inc >= i_cfg.hold_bright) begin
                    n_phase = S_FALL;
                    n_step  = StepTop;
                end
            end
            S_FALL: begin
                o_res.phase = PhFall;
                level = level_lookup(r_step[IdxW-1:0]);
                if (r_step != '0) begin
                    n_step = r_step - 8'd1;
                end else begin
                    n_phase = (i_cfg.hold_dark != '0) ? S_DARK : S_RISE;
                end
            end
            S_DARK: begin
                o_res.phase = PhDark;
                level  = LevelDark;
                n_step = step_inc;
                if (step_inc >= i_cfg.hold_dark) begin
                    n_phase = S_RISE;
                    n_step  = '0;
                end
            end
            default: begin
                n_phase = S_RISE;
                n_step  = '0;
            end
        endcase
        o_res.blue_duty   = i_colour_code[0] ? level : '0;
        o_res.orange_duty = i_colour_code[1] ? level : '0;
    end

    // advance only on a firing tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_RISE;
            r_step  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_step  <= n_step;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lbs_outbuf.sv @@
// Result register with one skid entry, so input acceptance never waits on
// the output stall combinationally. Depends on lbs_pkg.
`default_nettype none

module lbs_outbuf
    import lbs_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_res_valid,
    input  wire t_res i_res,
    input  wire logic i_out_stall,
    output logic      o_full,
    output logic      o_valid,
    output t_res      o_res
);

    logic r_out_valid, r_skid_valid;
    t_res r_out, r_skid;
    logic out_take;

    assign out_take = r_out_valid && !i_out_stall;
    assign o_full   = r_skid_valid;
    assign o_valid  = r_out_valid;
    assign o_res    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            // drain skid first; nothing new arrives while it is full
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= i_res_valid;
        end else if (i_res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out <= r_skid;
            end
        end else if (!r_out_valid || out_take) begin
            if (i_res_valid) begin
                r_out <= i_res;
            end
        end else if (i_res_valid) begin
            r_skid <= i_res;
        end
    end

endmodule

`default_nettype wire

@@ verif/led_breathe_sequencer_unit_checker.sv @@
// Checker for led_breathe_sequencer_unit: predicts each result word and compares it.
// Watches the config port and both channels; depends on lbs_pkg.
module led_breathe_sequencer_unit_checker
    import lbs_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [CntW-1:0]  i_cfg_data,
    input  wire logic             i_in_valid,
    input  wire logic             i_in_stall,
    input  wire logic [ColW-1:0]  i_colour_code,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_stall,
    input  wire logic [DutyW-1:0] i_blue_duty,
    input  wire logic [DutyW-1:0] i_orange_duty,
    input  wire logic [1:0]       i_phase,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked
);

    logic [DutyW-1:0] fade_lut [0:63] = '{
        5'd1,  5'd1,  5'd1,  5'd1,  5'd2,  5'd2,  5'd2,  5'd2,
        5'd3,  5'd3,  5'd3,  5'd3,  5'd4,  5'd4,  5'd4,  5'd5,
        5'd5,  5'd5,  5'd6,  5'd6,  5'd6,  5'd7,  5'd7,  5'd7,
        5'd8,  5'd8,  5'd8,  5'd9,  5'd9,  5'd10, 5'd10, 5'd11,
        5'd11, 5'd12, 5'd12, 5'd13, 5'd13, 5'd14, 5'd14, 5'd15,
        5'd15, 5'd16, 5'd16, 5'd17, 5'd17, 5'd18, 5'd18, 5'd19,
        5'd19, 5'd20, 5'd20, 5'd21, 5'd21, 5'd22, 5'd22, 5'd23,
        5'd23, 5'd24, 5'd25, 5'd26, 5'd27, 5'd28, 5'd29, 5'd31
    };

    // mirrored registers and sequencer state
    t_cfg            shadow_cfg;
    logic [CntW-1:0] tick_count;
    logic [1:0]      fade_phase;
    logic [CntW-1:0] fade_step;

    t_res predicted_duties [$];
    int   fails;
    int   checked;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        fails        = 0;
        checked      = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        fails++;
    endtask

    // Step the prescaler on one tick word; queue a result when it fires.
    task automatic advance_fade(input logic [ColW-1:0] colour);
        logic [DutyW-1:0] lvl;
        t_res             res;
        tick_count = tick_count + 8'd1;
        if (tick_count >= shadow_cfg.tick_gap) begin
            tick_count = '0;
            res.phase = fade_phase;
            case (fade_phase)
                PhRise: begin
                    lvl = fade_lut[fade_step[IdxW-1:0]];
                    fade_step = fade_step + 8'd1;
                    if (fade_step > StepTop) begin
                        if (shadow_cfg.hold_bright != '0) begin
                            fade_phase = PhBright;
                            fade_step  = '0;
                        end else begin
                            fade_phase = PhFall;
                            fade_step  = StepTop;
                        end
                    end
                end
                PhBright: begin
                    lvl = fade_lut[63];
                    fade_step = fade_step + 8'd1;
                    if (fade_step >= shadow_cfg.hold_bright) begin
                        fade_phase = PhFall;
                        fade_step  = StepTop;
                    end
                end
                PhFall: begin
                    lvl = fade_lut[fade_step[IdxW-1:0]];
                    if (fade_step != '0) begin
                        fade_step = fade_step - 8'd1;
                    end else begin
                        fade_phase = (shadow_cfg.hold_dark != '0) ? PhDark : PhRise;
                    end
                end
                default: begin
                    lvl = LevelDark;
                    fade_step = fade_step + 8'd1;
                    if (fade_step >= shadow_cfg.hold_dark) begin
                        fade_phase = PhRise;
                        fade_step  = '0;
                    end
                end
            endcase
            res.blue_duty   = colour[0] ? lvl : '0;
            res.orange_duty = colour[1] ? lvl : '0;
            predicted_duties.push_back(res);
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            shadow_cfg.tick_gap    = 8'd1;
            shadow_cfg.hold_bright = '0;
            shadow_cfg.hold_dark   = '0;
            tick_count = '0;
            fade_phase = PhRise;
            fade_step  = '0;
            predicted_duties.delete();
        end else begin
            // drain the result side before adding new predictions
            if (i_out_valid && !i_out_stall) begin
                if (predicted_duties.size() == 0) begin
                    report_mismatch("result word with nothing pending, phase", i_phase, -1);
                end else begin
                    want = predicted_duties.pop_front();
                    checked++;
                    if (i_blue_duty !== want.blue_duty)
                        report_mismatch("blue duty", i_blue_duty, want.blue_duty);
                    if (i_orange_duty !== want.orange_duty)
                        report_mismatch("orange duty", i_orange_duty, want.orange_duty);
                    if (i_phase !== want.phase)
                        report_mismatch("phase", i_phase, want.phase);
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    RegTickGap:    shadow_cfg.tick_gap    = i_cfg_data;
                    RegHoldBright: shadow_cfg.hold_bright = i_cfg_data;
                    RegHoldDark:   shadow_cfg.hold_dark   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                advance_fade(i_colour_code);
        end
        o_fail_count <= fails;
        o_pending    <= predicted_duties.size();
        o_checked    <= checked;
    end

endmodule

@@ verif/led_breathe_sequencer_unit_tb.sv @@
// Testbench top for led_breathe_sequencer_unit: clock, reset, tick words and register settings.
// Depends on lbs_pkg, the block and led_breathe_sequencer_unit_checker.
module led_breathe_sequencer_unit_tb;
    import lbs_pkg::*;

    // index 3 is outside the register list; the block must ignore it
    localparam logic [1:0] RegUnused = 2'd3;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             i_cfg_we      = 1'b0;
    logic [1:0]       i_cfg_index   = '0;
    logic [CntW-1:0]  i_cfg_data    = '0;
    logic             i_in_valid    = 1'b0;
    logic [ColW-1:0]  i_colour_code = '0;
    logic             i_out_stall   = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [DutyW-1:0] o_blue_duty;
    logic [DutyW-1:0] o_orange_duty;
    logic [1:0]       o_phase;

    int fail_count;
    int pending;
    int checked;

    // quiet: hold both sides busy, no idle cycles at all
    bit quiet    = 1'b0;
    int ticks    = 0;
    int settings = 0;

    led_breathe_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_colour_code (i_colour_code),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_blue_duty   (o_blue_duty),
        .o_orange_duty (o_orange_duty),
        .o_phase       (o_phase)
    );

    led_breathe_sequencer_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_colour_code (i_colour_code),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_blue_duty   (o_blue_duty),
        .i_orange_duty (o_orange_duty),
        .i_phase       (o_phase),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Receiver: stall about 27 percent of the time, except in the quiet stretch.
    always @(posedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(0, 99) < 27);
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #800000;
        $display("timeout: %0d results still pending", pending);
        $display("CHECK FAILED");
        $finish;
    end

    // Present one tick word, idling first at random, and hold it until taken.
    task automatic send_tick(input logic [ColW-1:0] colour);
        while (!quiet && $urandom_range(0, 99) < 27) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_colour_code <= colour;
        ticks++;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Drop valid, wait for every predicted result, then let the pipeline empty.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write one register; the enable stays high until cfg_done drops it.
    task automatic write_reg(input logic [1:0] idx, input logic [CntW-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
        settings++;
        @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [CntW-1:0] gap, input logic [CntW-1:0] bright,
                                  input logic [CntW-1:0] dark);
        write_reg(RegTickGap, gap);
        write_reg(RegHoldBright, bright);
        write_reg(RegHoldDark, dark);
        cfg_done();
    endtask

    // Hold length: mostly zero, one or short, now and then anything.
    function automatic logic [CntW-1:0] pick_hold();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'($urandom_range(2, 8));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [CntW-1:0] gap;
        logic [CntW-1:0] bright;
        logic [CntW-1:0] dark;
        int              count;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, every colour code including none.
        send_tick(2'd0);
        send_tick(2'd1);
        send_tick(2'd2);
        send_tick(2'd3);
        send_tick(2'd3);
        send_tick(2'd0);
        settle();

        // Write beyond the list must be ignored; gap 0 fires every tick.
        write_reg(RegUnused, 8'hff);
        write_reg(RegTickGap, 8'd0);
        cfg_done();
        send_tick(2'd3);
        send_tick(2'd2);
        send_tick(2'd1);
        send_tick(2'd0);
        send_tick(2'd1);
        send_tick(2'd3);
        settle();

        // Gap 2 with one-step holds.
        write_settings(8'd2, 8'd1, 8'd1);
        for (int i = 0; i < 8; i++) send_tick(2'(i));
        settle();

        // Random phases; the sequencer state carries across each rewrite.
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin
                    // full rise and fall with no holds
                    gap = 8'd1;  bright = 8'd0;   dark = 8'd0;   count = 150;
                end
                1: begin
                    gap = 8'd0;  bright = 8'd255; dark = 8'd255; count = 140;
                end
                2: begin
                    // slowest prescaler: the count climbs all the way to 255
                    gap = 8'd255; bright = pick_hold(); dark = pick_hold(); count = 260;
                end
                3: begin
                    gap = 8'd0;  bright = 8'd200; dark = 8'd200; count = 60;
                end
                4: begin
                    // lowered holds end any hold in progress on the next firing
                    gap = 8'd0;  bright = 8'd1;   dark = 8'd1;   count = 40;
                end
                default: begin
                    gap = 8'($urandom_range(0, 3));
                    bright = pick_hold();
                    dark = pick_hold();
                    count = 20;
                end
            endcase
            write_settings(gap, bright, dark);
            for (int i = 0; i < count; i++) begin
                quiet = (p == 0) && (i >= 20) && (i < 120);
                send_tick(2'($urandom_range(0, 3)));
            end
            quiet = 1'b0;
            settle();
        end

        repeat (8) @(posedge i_clk);
        $display("run covered %0d tick words under %0d register settings", ticks, settings);
        $display("%0d result words checked field by field", checked);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/lbs_pkg.sv
rtl/lbs_prescale.sv
rtl/lbs_seq.sv
rtl/lbs_outbuf.sv
rtl/led_breathe_sequencer_unit.sv
verif/led_breathe_sequencer_unit_checker.sv
verif/led_breathe_sequencer_unit_tb.sv
